[src/bcg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear colour gradient package
// Shared widths, register indexes, setup sequencer states and helpers.
// ----------------------------------------------------------------------------
package bcg_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int CHAN_W     = 8;
	localparam int FIX_W      = CHAN_W + FRAC_BITS;
	localparam int DIV_W      = FIX_W + 1;
	localparam int SIDE_W     = 12;
	localparam int CFG_SIDE_W = 13;
	localparam int MAX_SIDE   = 4096;
	localparam int RGB_W      = 3 * CHAN_W;
	localparam int ADDR_W     = 5;
	localparam int NUM_STAGES = 9;
	localparam int NUM_CHAN   = 3;
	localparam int NUM_INC    = 2 * NUM_CHAN;
	localparam int JOB_W      = 3;

	localparam logic [JOB_W-1:0]  JOB_RECIP = JOB_W'(NUM_INC);
	localparam logic [CHAN_W-1:0] ALPHA     = 8'hFF;

	localparam logic [RGB_W-1:0]      RST_TOP_LEFT     = 24'hFF0000;
	localparam logic [RGB_W-1:0]      RST_TOP_RIGHT    = 24'h0000FF;
	localparam logic [RGB_W-1:0]      RST_BOTTOM_LEFT  = 24'hFFFF00;
	localparam logic [RGB_W-1:0]      RST_BOTTOM_RIGHT = 24'h00FF00;
	localparam logic [CFG_SIDE_W-1:0] RST_WIDTH        = 13'd320;
	localparam logic [CFG_SIDE_W-1:0] RST_HEIGHT       = 13'd240;

	typedef enum logic [2:0] {
		REG_TOP_LEFT     = 3'd0,
		REG_TOP_RIGHT    = 3'd1,
		REG_BOTTOM_LEFT  = 3'd2,
		REG_BOTTOM_RIGHT = 3'd3,
		REG_WIDTH        = 3'd4,
		REG_HEIGHT       = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_ISSUE,
		SEQ_WAIT
	} seq_state_t;

	// Load enables for the lane stages, one per pipeline register.
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
		logic en_s6;
		logic en_s7;
		logic en_s8;
		logic en_s9;
	} lane_ctl_t;

	// Frame side minus one, with the side held to 2..MAX_SIDE.
	function automatic logic [SIDE_W-1:0] side_m1(input logic [CFG_SIDE_W-1:0] v);
		logic [CFG_SIDE_W-1:0] t;
		t = v - CFG_SIDE_W'(1);
		if (v < CFG_SIDE_W'(2)) begin
			side_m1 = SIDE_W'(1);
		end else if (v > CFG_SIDE_W'(MAX_SIDE)) begin
			side_m1 = SIDE_W'(MAX_SIDE - 1);
		end else begin
			side_m1 = t[SIDE_W-1:0];
		end
	endfunction

	// Channel 0 is red, 1 green, 2 blue.
	function automatic logic [CHAN_W-1:0] chan_byte(input logic [RGB_W-1:0] rgb,
		input logic [1:0] idx);
		case (idx)
			2'd0: chan_byte = rgb[23:16];
			2'd1: chan_byte = rgb[15:8];
			default: chan_byte = rgb[7:0];
		endcase
	endfunction

endpackage
`default_nettype wire

[src/bcg_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear colour gradient serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcg_div
	import bcg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_W-1:0]  num,
	input  wire logic [SIDE_W-1:0] den,
	output logic                   done,
	output logic [DIV_W-1:0]       quot
);

	localparam int CNT_W = $clog2(DIV_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SIDE_W-1:0] rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [SIDE_W:0]   trial;
	logic [SIDE_W:0]   trial_sub;
	logic              fits;

	// The remainder stays below the divisor, so it never needs more bits.
	assign trial     = {rem_q, quo_q[DIV_W-1]};
	assign trial_sub = trial - {1'b0, den};
	assign fits      = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[SIDE_W-1:0] : trial[SIDE_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

[src/bcg_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear colour gradient channel lane
// Stages two to nine of one colour channel: row edges, row step, pixel value.
// ----------------------------------------------------------------------------
module bcg_lane
	import bcg_pkg::*;
(
	input  wire logic                     clk,
	input  wire lane_ctl_t                ctl,
	input  wire logic [SIDE_W-1:0]        px_s1,
	input  wire logic [SIDE_W-1:0]        py_s1,
	input  wire logic [CHAN_W-1:0]        top_left,
	input  wire logic [CHAN_W-1:0]        top_right,
	input  wire logic signed [FIX_W:0]    inc_left,
	input  wire logic signed [FIX_W:0]    inc_right,
	input  wire logic [DIV_W-1:0]         recip,
	input  wire logic [SIDE_W-1:0]        width_m1,
	output logic [CHAN_W-1:0]             chan_s9
);

	logic signed [FIX_W+SIDE_W+1:0] prod_l;
	logic signed [FIX_W+SIDE_W+1:0] prod_r;
	logic signed [FIX_W:0]          sum_l;
	logic signed [FIX_W:0]          sum_r;
	logic signed [FIX_W:0]          diff;
	logic signed [FIX_W:0]          diff_neg;
	logic [2*FIX_W:0]               est;
	logic [FIX_W+SIDE_W-1:0]        qd;
	logic [FIX_W-1:0]               rem;
	logic [FIX_W+SIDE_W-1:0]        hp;
	logic [FIX_W:0]                 val;

	logic signed [FIX_W:0] prod_l_s2, prod_r_s2;
	logic [SIDE_W-1:0]     px_s2, px_s3, px_s4, px_s5, px_s6, px_s7;
	logic [FIX_W-1:0]      edge_l_s3, edge_r_s3;
	logic [FIX_W-1:0]      edge_l_s4, edge_l_s5, edge_l_s6, edge_l_s7, edge_l_s8;
	logic [FIX_W-1:0]      mag_s4, mag_s5, mag_s6;
	logic                  neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [FIX_W-1:0]      q_s5, q_s6;
	logic [FIX_W-1:0]      qd_s6;
	logic [FIX_W-1:0]      step_s7;
	logic [FIX_W-1:0]      hp_s8;

	// Stage 2: row offset along each vertical edge.
	assign prod_l = $signed({1'b0, py_s1}) * inc_left;
	assign prod_r = $signed({1'b0, py_s1}) * inc_right;

	// Stage 3: edge values at this row; both stay within 0..255 in fixed point.
	assign sum_l = $signed({1'b0, top_left, {FRAC_BITS{1'b0}}}) + prod_l_s2;
	assign sum_r = $signed({1'b0, top_right, {FRAC_BITS{1'b0}}}) + prod_r_s2;

	// Stage 4: span across the row as sign and magnitude.
	assign diff     = $signed({1'b0, edge_r_s3}) - $signed({1'b0, edge_l_s3});
	assign diff_neg = -diff;

	// Stage 5: quotient estimate from the reciprocal, low by at most one.
	assign est = mag_s4 * recip;

	// Stages 6 and 7: check the estimate and correct it.
	assign qd  = q_s5 * width_m1;
	assign rem = mag_s6 - qd_s6;

	// Stage 8: offset of the pixel from the left edge.
	assign hp = px_s7 * step_s7;

	// Stage 9: final value, then the integer part.
	assign val = neg_s8 ? ({1'b0, edge_l_s8} - {1'b0, hp_s8})
	                    : ({1'b0, edge_l_s8} + {1'b0, hp_s8});

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			prod_l_s2 <= prod_l[FIX_W:0];
			prod_r_s2 <= prod_r[FIX_W:0];
			px_s2     <= px_s1;
		end
		if (ctl.en_s3) begin
			edge_l_s3 <= sum_l[FIX_W-1:0];
			edge_r_s3 <= sum_r[FIX_W-1:0];
			px_s3     <= px_s2;
		end
		if (ctl.en_s4) begin
			neg_s4    <= diff[FIX_W];
			mag_s4    <= diff[FIX_W] ? diff_neg[FIX_W-1:0] : diff[FIX_W-1:0];
			edge_l_s4 <= edge_l_s3;
			px_s4     <= px_s3;
		end
		if (ctl.en_s5) begin
			q_s5      <= est[2*FIX_W-1:FIX_W];
			mag_s5    <= mag_s4;
			neg_s5    <= neg_s4;
			edge_l_s5 <= edge_l_s4;
			px_s5     <= px_s4;
		end
		if (ctl.en_s6) begin
			qd_s6     <= qd[FIX_W-1:0];
			q_s6      <= q_s5;
			mag_s6    <= mag_s5;
			neg_s6    <= neg_s5;
			edge_l_s6 <= edge_l_s5;
			px_s6     <= px_s5;
		end
		if (ctl.en_s7) begin
			step_s7   <= (rem >= {{(FIX_W-SIDE_W){1'b0}}, width_m1})
			             ? (q_s6 + FIX_W'(1)) : q_s6;
			neg_s7    <= neg_s6;
			edge_l_s7 <= edge_l_s6;
			px_s7     <= px_s6;
		end
		if (ctl.en_s8) begin
			hp_s8     <= hp[FIX_W-1:0];
			neg_s8    <= neg_s7;
			edge_l_s8 <= edge_l_s7;
		end
		if (ctl.en_s9) begin
			if (val[FIX_W]) begin
				chan_s9 <= neg_s8 ? '0 : ALPHA;
			end else begin
				chan_s9 <= val[FIX_W-1:FRAC_BITS];
			end
		end
	end

endmodule
`default_nettype wire

[src/bilinear_colour_gradient.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear colour gradient pixel generator
// Returns the ARGB8888 colour of one pixel of a frame shaded between four
// configured corner colours.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  -------   ---------  --------------------  ------------------------------
//  input     in         in_valid / in_stall   pixel_x, pixel_y (12 bit each)
//  output    out        out_valid / out_stall pixel_colour (32 bit ARGB)
//  config    in         APB write/read        six registers at 4*i, 32 bit
//
// One request enters per cycle while in_stall is low; each colour passes
// nine register stages that each hold one multiplier or one add and compare.
// After reset and after every write to one of the six registers a setup pass
// runs the shared serial divider seven times (six vertical steps and the row
// reciprocal); in_stall is high during that pass.
// A held output stalls only the full stages behind it in the same cycle, so
// empty stages keep filling while the output is held, and no request is lost
// or repeated.
//
module bilinear_colour_gradient
	import bcg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [SIDE_W-1:0] pixel_x,
	input  wire logic [SIDE_W-1:0] pixel_y,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [31:0]            pixel_colour,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	// Configuration registers.
	logic [RGB_W-1:0]      top_left_q;
	logic [RGB_W-1:0]      top_right_q;
	logic [RGB_W-1:0]      bottom_left_q;
	logic [RGB_W-1:0]      bottom_right_q;
	logic [CFG_SIDE_W-1:0] width_q;
	logic [CFG_SIDE_W-1:0] height_q;

	logic     cfg_wr;
	logic     cfg_hit;
	reg_idx_t cfg_idx;

	logic [SIDE_W-1:0] width_m1;
	logic [SIDE_W-1:0] height_m1;

	// Setup sequencer and the values it leaves behind.
	seq_state_t        state_q, state_d;
	logic [JOB_W-1:0]  job_q, job_d;
	logic              busy;
	logic              div_start;
	logic              div_done;
	logic [DIV_W-1:0]  div_num;
	logic [SIDE_W-1:0] div_den;
	logic [DIV_W-1:0]  div_quot;
	logic [1:0]        job_chan;
	logic [CHAN_W-1:0] job_top;
	logic [CHAN_W-1:0] job_bot;
	logic [CHAN_W-1:0] job_mag;
	logic              job_neg;
	logic [DIV_W-1:0]  div_quot_neg;

	logic signed [FIX_W:0] inc_q [NUM_INC];
	logic [DIV_W-1:0]      recip_q;

	// Pipeline control.
	logic [NUM_STAGES:1] stage_vld_q;
	logic [NUM_STAGES:1] stage_rdy;
	logic                accept;
	lane_ctl_t           lane_ctl;

	logic [SIDE_W-1:0] px_s1;
	logic [SIDE_W-1:0] py_s1;
	logic [CHAN_W-1:0] chan_s9 [NUM_CHAN];

	// ------------------------------------------------------------------------
	// Register port. pready is tied high, so every access completes in its
	// access cycle; a write outside the register list is dropped.
	// ------------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_comb begin
		case (cfg_idx)
			REG_TOP_LEFT,
			REG_TOP_RIGHT,
			REG_BOTTOM_LEFT,
			REG_BOTTOM_RIGHT,
			REG_WIDTH,
			REG_HEIGHT: cfg_hit = 1'b1;
			default:    cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_left_q     <= RST_TOP_LEFT;
			top_right_q    <= RST_TOP_RIGHT;
			bottom_left_q  <= RST_BOTTOM_LEFT;
			bottom_right_q <= RST_BOTTOM_RIGHT;
			width_q        <= RST_WIDTH;
			height_q       <= RST_HEIGHT;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TOP_LEFT:     top_left_q     <= pwdata[RGB_W-1:0];
				REG_TOP_RIGHT:    top_right_q    <= pwdata[RGB_W-1:0];
				REG_BOTTOM_LEFT:  bottom_left_q  <= pwdata[RGB_W-1:0];
				REG_BOTTOM_RIGHT: bottom_right_q <= pwdata[RGB_W-1:0];
				REG_WIDTH:        width_q        <= pwdata[CFG_SIDE_W-1:0];
				REG_HEIGHT:       height_q       <= pwdata[CFG_SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_TOP_LEFT:     prdata = {8'd0, top_left_q};
			REG_TOP_RIGHT:    prdata = {8'd0, top_right_q};
			REG_BOTTOM_LEFT:  prdata = {8'd0, bottom_left_q};
			REG_BOTTOM_RIGHT: prdata = {8'd0, bottom_right_q};
			REG_WIDTH:        prdata = {{(32-CFG_SIDE_W){1'b0}}, width_q};
			REG_HEIGHT:       prdata = {{(32-CFG_SIDE_W){1'b0}}, height_q};
			default:          prdata = '0;
		endcase
	end

	// Frame sides are held to 2..4096 and used as side minus one throughout.
	assign width_m1  = side_m1(width_q);
	assign height_m1 = side_m1(height_q);

	// ------------------------------------------------------------------------
	// Setup pass. Jobs 0 to 5 compute the per-row step of each vertical edge
	// (channel in the upper bits, left or right edge in the low bit) as the
	// corner difference over height minus one, truncated toward zero. Job 6
	// computes floor(2^24 / (width - 1)), which lets the pipeline divide the
	// row span by a multiply and a single correction step. A write to a mapped
	// register restarts the pass from the first job.
	// ------------------------------------------------------------------------
	assign job_chan     = job_q[JOB_W-1:1];
	assign job_top      = chan_byte(job_q[0] ? top_right_q : top_left_q, job_chan);
	assign job_bot      = chan_byte(job_q[0] ? bottom_right_q : bottom_left_q, job_chan);
	assign job_neg      = job_bot < job_top;
	assign job_mag      = job_neg ? (job_top - job_bot) : (job_bot - job_top);
	assign div_quot_neg = -div_quot;

	always_comb begin
		if (job_q == JOB_RECIP) begin
			div_num = {1'b1, {FIX_W{1'b0}}};
			div_den = width_m1;
		end else begin
			div_num = {1'b0, job_mag, {FRAC_BITS{1'b0}}};
			div_den = height_m1;
		end
	end

	always_comb begin
		state_d   = state_q;
		job_d     = job_q;
		div_start = 1'b0;
		case (state_q)
			SEQ_IDLE: ;
			SEQ_ISSUE: begin
				div_start = 1'b1;
				state_d   = SEQ_WAIT;
			end
			SEQ_WAIT: begin
				if (div_done) begin
					if (job_q == JOB_RECIP) begin
						state_d = SEQ_IDLE;
					end else begin
						job_d   = job_q + 1'b1;
						state_d = SEQ_ISSUE;
					end
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
		if (cfg_wr && cfg_hit) begin
			state_d = SEQ_ISSUE;
			job_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_ISSUE;
			job_q   <= '0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_WAIT && div_done) begin
			if (job_q == JOB_RECIP) begin
				recip_q <= div_quot;
			end else begin
				inc_q[job_q] <= job_neg ? $signed(div_quot_neg) : $signed(div_quot);
			end
		end
	end

	assign busy = state_q != SEQ_IDLE;

	bcg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// ------------------------------------------------------------------------
	// Pipeline flow control. A stage takes new data when it is empty or when
	// the stage after it takes its contents, so a held output only blocks the
	// stages that are actually full.
	// ------------------------------------------------------------------------
	always_comb begin
		stage_rdy[NUM_STAGES] = !stage_vld_q[NUM_STAGES] || !out_stall;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			stage_rdy[k] = !stage_vld_q[k] || stage_rdy[k+1];
		end
	end

	assign in_stall = busy || !stage_rdy[1];
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_rdy[1]) begin
				stage_vld_q[1] <= accept;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (stage_rdy[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	assign lane_ctl.en_s2 = stage_rdy[2] && stage_vld_q[1];
	assign lane_ctl.en_s3 = stage_rdy[3] && stage_vld_q[2];
	assign lane_ctl.en_s4 = stage_rdy[4] && stage_vld_q[3];
	assign lane_ctl.en_s5 = stage_rdy[5] && stage_vld_q[4];
	assign lane_ctl.en_s6 = stage_rdy[6] && stage_vld_q[5];
	assign lane_ctl.en_s7 = stage_rdy[7] && stage_vld_q[6];
	assign lane_ctl.en_s8 = stage_rdy[8] && stage_vld_q[7];
	assign lane_ctl.en_s9 = stage_rdy[9] && stage_vld_q[8];

	// Stage 1: clamp the coordinate into the frame.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= (pixel_x > width_m1) ? width_m1 : pixel_x;
			py_s1 <= (pixel_y > height_m1) ? height_m1 : pixel_y;
		end
	end

	// One lane per colour channel: red, green, blue.
	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
		bcg_lane u_lane (
			.clk       (clk),
			.ctl       (lane_ctl),
			.px_s1     (px_s1),
			.py_s1     (py_s1),
			.top_left  (chan_byte(top_left_q, 2'(c))),
			.top_right (chan_byte(top_right_q, 2'(c))),
			.inc_left  (inc_q[2*c]),
			.inc_right (inc_q[2*c+1]),
			.recip     (recip_q),
			.width_m1  (width_m1),
			.chan_s9   (chan_s9[c])
		);
	end

	assign out_valid    = stage_vld_q[NUM_STAGES];
	assign pixel_colour = {ALPHA, chan_s9[0], chan_s9[1], chan_s9[2]};

endmodule
`default_nettype wire

[verif/bilinear_colour_gradient_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear colour gradient testbench
// Sends pixel requests in random bursts, predicts the ARGB colour of each one
// from a shadow copy of the corner and frame registers, and compares every
// colour that leaves the block against the oldest prediction. The registers
// are rewritten over the APB port between request batches.
// ----------------------------------------------------------------------------
module bilinear_colour_gradient_tb;
	import bcg_pkg::*;

	// A write to this index lands on an address with no register behind it.
	localparam logic [2:0] UNMAPPED_REG = 3'd6;
	// The longest quiet stretch of a correct run is the setup pass after a
	// register write, so this leaves ample margin.
	localparam int QUIET_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1300;

	typedef struct packed {
		logic [SIDE_W-1:0] x;
		logic [SIDE_W-1:0] y;
	} pixel_req_t;

	typedef struct packed {
		logic [SIDE_W-1:0] x;
		logic [SIDE_W-1:0] y;
		logic [31:0]       colour;
	} colour_due_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [SIDE_W-1:0] pixel_x = '0;
	logic [SIDE_W-1:0] pixel_y = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [31:0]       pixel_colour;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	// Requests waiting to be driven, and colours waiting to come back.
	pixel_req_t  pixel_feed[$];
	colour_due_t colour_due[$];

	// Shadow of the block's registers, updated at the edge of each write.
	logic [RGB_W-1:0]      corner_rgb [4];
	logic [CFG_SIDE_W-1:0] frame_w_cfg = RST_WIDTH;
	logic [CFG_SIDE_W-1:0] frame_h_cfg = RST_HEIGHT;

	int          burst_left = 0;
	int          gap_left = 0;
	int          stall_mode = 0;
	int          stall_span = 0;
	int          stall_tick = 0;
	int          mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	bilinear_colour_gradient dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_colour (pixel_colour),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #1 clk = ~clk;

	// Frame sides outside 2..MAX_SIDE behave as the nearest legal side.
	function automatic int unsigned effective_side(input logic [CFG_SIDE_W-1:0] v);
		if (v < 2) begin
			return 2;
		end
		if (v > MAX_SIDE) begin
			return MAX_SIDE;
		end
		return v;
	endfunction

	// One channel of a corner colour, scaled to fixed point.
	function automatic longint corner_fixed(input int corner, input int ch);
		logic [CHAN_W-1:0] c;
		c = corner_rgb[corner][RGB_W-1-CHAN_W*ch -: CHAN_W];
		return longint'(c) <<< FRAC_BITS;
	endfunction

	// Point idx of an n-point ramp; the step is truncated toward zero and the
	// fraction of the result is kept for the next stage of interpolation.
	function automatic longint ramp_point(input longint start_v, input longint end_v,
		input int unsigned idx, input int unsigned n);
		longint step;
		step = (end_v - start_v) / longint'(n - 1);
		return start_v + longint'(idx) * step;
	endfunction

	// Colour of one pixel under the current shadow registers. Each channel runs
	// down both frame edges to the pixel's row, then across the row.
	function automatic logic [31:0] predict_colour(input logic [SIDE_W-1:0] x,
		input logic [SIDE_W-1:0] y);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned row;
		longint      west;
		longint      east;
		longint      shade;
		logic [31:0] argb;
		w = effective_side(frame_w_cfg);
		h = effective_side(frame_h_cfg);
		col = (x > w - 1) ? w - 1 : x;
		row = (y > h - 1) ? h - 1 : y;
		argb = {ALPHA, {RGB_W{1'b0}}};
		for (int ch = 0; ch < NUM_CHAN; ch++) begin
			west = ramp_point(corner_fixed(REG_TOP_LEFT, ch),
				corner_fixed(REG_BOTTOM_LEFT, ch), row, h);
			east = ramp_point(corner_fixed(REG_TOP_RIGHT, ch),
				corner_fixed(REG_BOTTOM_RIGHT, ch), row, h);
			shade = ramp_point(west, east, col, w);
			// Saturation cannot trigger with truncated steps, but costs nothing.
			if (shade < 0) begin
				shade = 0;
			end else begin
				shade = shade >>> FRAC_BITS;
				if (shade > 255) begin
					shade = 255;
				end
			end
			argb[RGB_W-1-CHAN_W*ch -: CHAN_W] = shade[CHAN_W-1:0];
		end
		return argb;
	endfunction

	// Coordinates mostly fall inside the frame, with the edges and the far
	// clamped range mixed in.
	function automatic logic [SIDE_W-1:0] rand_coord(input int unsigned side);
		case ($urandom_range(0, 9))
			0: return SIDE_W'($urandom);
			1: return SIDE_W'(side - 1);
			2: return '0;
			3: return SIDE_W'($urandom_range(side - 1, MAX_SIDE - 1));
			default: return SIDE_W'($urandom_range(0, side - 1));
		endcase
	endfunction

	// Mostly small frames keep the ramps short and the coverage dense; the
	// out-of-range and maximum sides still show up. Upper bits carry noise.
	function automatic logic [31:0] rand_side_word();
		int unsigned v;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, 1);
			1: v = $urandom_range(MAX_SIDE + 1, 8191);
			2: v = MAX_SIDE;
			3: v = 2;
			4, 5: v = $urandom_range(2, MAX_SIDE);
			default: v = $urandom_range(2, 64);
		endcase
		return ($urandom & 32'hFFFF_E000) | 32'(v);
	endfunction

	function automatic logic [31:0] rand_colour_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// APB write: setup cycle, then an access cycle whose closing edge commits.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_TOP_LEFT:     corner_rgb[REG_TOP_LEFT]     = value[RGB_W-1:0];
			REG_TOP_RIGHT:    corner_rgb[REG_TOP_RIGHT]    = value[RGB_W-1:0];
			REG_BOTTOM_LEFT:  corner_rgb[REG_BOTTOM_LEFT]  = value[RGB_W-1:0];
			REG_BOTTOM_RIGHT: corner_rgb[REG_BOTTOM_RIGHT] = value[RGB_W-1:0];
			REG_WIDTH:        frame_w_cfg = value[CFG_SIDE_W-1:0];
			REG_HEIGHT:       frame_h_cfg = value[CFG_SIDE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic queue_pixel(input logic [SIDE_W-1:0] x, input logic [SIDE_W-1:0] y);
		pixel_req_t req;
		req.x = x;
		req.y = y;
		pixel_feed.insert(pixel_feed.size(), req);
	endtask

	// Wait until every request has been sent and answered, then let the
	// pipeline run empty before anything touches the registers.
	task automatic drain_pipeline();
		while (pixel_feed.size() != 0 || in_valid || colour_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (NUM_STAGES + 3) @(posedge clk);
	endtask

	// Request driver. A request is taken at an edge with in_valid high and
	// in_stall low; that is when its colour is predicted, since the registers
	// cannot change while requests are in flight. Requests go out in bursts
	// separated by gaps of random length, some of them zero.
	always @(posedge clk) begin
		pixel_req_t  req;
		colour_due_t due;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				due.x = pixel_x;
				due.y = pixel_y;
				due.colour = predict_colour(pixel_x, pixel_y);
				colour_due.insert(colour_due.size(), due);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pixel_feed.size() != 0) begin
					req = pixel_feed.pop_front();
					in_valid <= 1'b1;
					pixel_x <= req.x;
					pixel_y <= req.y;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Colour monitor and output stall pattern. The stall switches between
	// spans of no stall, light random stall, heavy random stall and a fixed
	// one-in-three pattern, so the held output lands on every pipeline phase.
	always @(posedge clk) begin
		colour_due_t due;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (colour_due.size() == 0) begin
					$display("%0t: colour expected none, got %08h", $time, pixel_colour);
					mismatch_count++;
				end else begin
					due = colour_due.pop_front();
					if (pixel_colour !== due.colour) begin
						$display("%0t: pixel (%0d,%0d) colour expected %08h, got %08h",
							$time, due.x, due.y, due.colour, pixel_colour);
						mismatch_count++;
					end
				end
			end
			if (stall_span == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_span = $urandom_range(20, 200);
			end else begin
				stall_span--;
			end
			stall_tick++;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (stall_tick % 3 == 0);
			endcase
		end
	end

	// Any accepted request, colour or register write counts as progress.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int unsigned random_count;
		int unsigned batch;
		int unsigned w;
		int unsigned h;
		corner_rgb[REG_TOP_LEFT]     = RST_TOP_LEFT;
		corner_rgb[REG_TOP_RIGHT]    = RST_TOP_RIGHT;
		corner_rgb[REG_BOTTOM_LEFT]  = RST_BOTTOM_LEFT;
		corner_rgb[REG_BOTTOM_RIGHT] = RST_BOTTOM_RIGHT;
		random_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values, 320 by 240: the four corners, the centre, clamping on
		// each axis and alternating bit patterns on both coordinates.
		queue_pixel(0, 0);
		queue_pixel(319, 0);
		queue_pixel(0, 239);
		queue_pixel(319, 239);
		queue_pixel(160, 120);
		queue_pixel(12'hFFF, 12'hFFF);
		queue_pixel(12'hFFF, 0);
		queue_pixel(0, 12'hFFF);
		queue_pixel(12'hAAA, 12'h555);
		queue_pixel(12'h555, 12'hAAA);
		queue_pixel(1, 238);
		drain_pipeline();

		// Sides below two are treated as two; opposite corners white and black.
		// The unmapped write must leave every register alone.
		write_reg(REG_TOP_LEFT, 32'h00FF_FFFF);
		write_reg(REG_TOP_RIGHT, 32'h0000_0000);
		write_reg(REG_BOTTOM_LEFT, 32'h0000_0000);
		write_reg(REG_BOTTOM_RIGHT, 32'hFFFF_FFFF);
		write_reg(REG_WIDTH, 32'h0000_0000);
		write_reg(REG_HEIGHT, 32'h0000_0001);
		write_reg(UNMAPPED_REG, 32'hFFFF_FFFF);
		@(posedge clk);
		queue_pixel(0, 0);
		queue_pixel(1, 1);
		queue_pixel(1, 0);
		queue_pixel(0, 1);
		queue_pixel(12'hFFF, 12'hFFF);
		drain_pipeline();

		// Largest frame: a width above the maximum is held to the maximum, so
		// the steps are at their finest. Noise sits above the colour field.
		write_reg(REG_TOP_LEFT, 32'hFF00_0000);
		write_reg(REG_TOP_RIGHT, 32'h00FF_FFFF);
		write_reg(REG_BOTTOM_LEFT, 32'h00FF_FFFF);
		write_reg(REG_BOTTOM_RIGHT, 32'h0000_0000);
		write_reg(REG_WIDTH, 32'h0000_1FFF);
		write_reg(REG_HEIGHT, 32'(MAX_SIDE));
		@(posedge clk);
		queue_pixel(12'hFFF, 12'hFFF);
		queue_pixel(2048, 2047);
		queue_pixel(0, 12'hFFF);
		queue_pixel(12'hFFF, 0);
		queue_pixel(4094, 1);
		drain_pipeline();

		// Random batches, each under a freshly shuffled set of registers.
		while (random_count < RANDOM_ITEMS) begin
			for (int r = REG_TOP_LEFT; r <= REG_BOTTOM_RIGHT; r++) begin
				if ($urandom_range(0, 1) == 0) begin
					write_reg(3'(r), rand_colour_word());
				end
			end
			if ($urandom_range(0, 1) == 0) begin
				write_reg(REG_WIDTH, rand_side_word());
			end
			if ($urandom_range(0, 1) == 0) begin
				write_reg(REG_HEIGHT, rand_side_word());
			end
			if ($urandom_range(0, 7) == 0) begin
				write_reg(UNMAPPED_REG, $urandom);
			end
			@(posedge clk);
			w = effective_side(frame_w_cfg);
			h = effective_side(frame_h_cfg);
			batch = $urandom_range(40, 160);
			repeat (batch) queue_pixel(rand_coord(w), rand_coord(h));
			random_count += batch;
			drain_pipeline();
		end

		if (mismatch_count == 0 && colour_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
